// File: rtl/lc3b_microcoded_datapath_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LC-3b microcoded datapath unit
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LC3B_MICROCODED_DATAPATH_UNIT_MACROS_SVH
`define LC3B_MICROCODED_DATAPATH_UNIT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define LC3BMD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define LC3BMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lc3bmd_pkg.sv
// ----------------------------------------------------------------------------
// lc3bmd_pkg
// Types, constants and helpers of the LC-3b microcoded datapath unit.
// ----------------------------------------------------------------------------
package lc3bmd_pkg;

  localparam int MEM_WORDS_DEF = 32768;
  localparam int CS_ROWS       = 64;
  localparam int CS_AW         = $clog2(CS_ROWS);
  localparam int NUM_REGS      = 8;
  localparam int MEM_LATENCY   = 5;
  localparam logic [5:0] START_STATE = 6'd18;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WR_CS = 2'd1;
  localparam logic [1:0] OP_WR_MEM = 2'd2;
  localparam logic [1:0] OP_RD_MEM = 2'd3;

  localparam logic [1:0] COND_NONE  = 2'd0;
  localparam logic [1:0] COND_READY = 2'd1;
  localparam logic [1:0] COND_BEN   = 2'd2;
  localparam logic [1:0] COND_ADDR  = 2'd3;

  localparam logic [2:0] CC_N = 3'b100;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_P = 3'b001;

  typedef struct packed {
    logic       ird;
    logic [1:0] cond;
    logic [5:0] j;
    logic       ld_mar;
    logic       ld_mdr;
    logic       ld_ir;
    logic       ld_ben;
    logic       ld_reg;
    logic       ld_cc;
    logic       ld_pc;
    logic       drv_pc;
    logic       drv_mdr;
    logic       drv_alu;
    logic       drv_marmux;
    logic       drv_shf;
    logic [1:0] pcmux;
    logic       drmux;
    logic       sr1mux;
    logic       addr1mux;
    logic [1:0] addr2mux;
    logic       marmux;
    logic [1:0] aluk;
    logic       mio_en;
    logic       r_w;
    logic       wsize;
    logic       lshf1;
  } uinst_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] index;
    logic [34:0] data;
  } in_t;

  typedef struct packed {
    logic [5:0]  micro_state_out;
    logic [15:0] bus_value;
    logic [15:0] pc_value;
    logic [15:0] ir_value;
    logic [2:0]  cc_nzp;
    logic        halted;
    logic [15:0] read_data;
  } out_t;

  typedef struct packed {
    logic        en;
    logic [14:0] addr;
    logic [15:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [CS_AW-1:0] addr;
    uinst_t           data;
  } cs_wr_t;

  function automatic logic [15:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  function automatic logic [15:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

endpackage

// File: rtl/lc3bmd_cstore.sv
// ----------------------------------------------------------------------------
// lc3bmd_cstore
// Writable control store; the registered read tracks the next microstate.
// ----------------------------------------------------------------------------
module lc3bmd_cstore
  import lc3bmd_pkg::*;
(
  input  logic             clk,
  input  cs_wr_t           wr,
  input  logic [CS_AW-1:0] raddr,
  output uinst_t           rdata
);

  uinst_t mem [CS_ROWS];
  uinst_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // forward a write that hits the row being fetched
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == raddr)) begin
      rdata_r <= wr.data;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lc3bmd_mem.sv
// ----------------------------------------------------------------------------
// lc3bmd_mem
// Main word memory with clearing pass, MAR-tracking port and console port.
// ----------------------------------------------------------------------------
module lc3bmd_mem
  import lc3bmd_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mem_wr_t     wr,
  input  logic [14:0] raddr_a,
  output logic [15:0] rdata_a,
  input  logic        rd_b_en,
  input  logic        rd_b_sel,
  input  logic [14:0] raddr_b,
  output logic [15:0] rdata_b,
  output logic        busy
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [15:0]   mem [MEM_WORDS];
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;
  logic          wen;
  logic [14:0]   waddr;
  logic [15:0]   wdata;
  logic [15:0]   a_q_r;
  logic          a_ok_r;
  logic [15:0]   b_q_r;
  logic          b_ok_r;

  always_comb begin
    if (clr_r) begin
      wen   = 1'b1;
      waddr = 15'(clr_cnt_r);
      wdata = '0;
    end else begin
      wen   = wr.en && ({1'b0, wr.addr} < 16'(MEM_WORDS));
      waddr = wr.addr;
      wdata = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  // port A follows the word under MAR; forward a same-edge write
  always_ff @(posedge clk) begin
    a_ok_r <= {1'b0, raddr_a} < 16'(MEM_WORDS);
    if (wen && (waddr == raddr_a)) begin
      a_q_r <= wdata;
    end else begin
      a_q_r <= mem[raddr_a[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b_en) begin
      b_ok_r <= rd_b_sel && ({1'b0, raddr_b} < 16'(MEM_WORDS));
      b_q_r  <= mem[raddr_b[AW-1:0]];
    end
  end

  assign rdata_a = a_ok_r ? a_q_r : '0;
  assign rdata_b = b_ok_r ? b_q_r : '0;
  assign busy    = clr_r;

endmodule

// File: rtl/lc3b_microcoded_datapath_unit.sv
// Result: the result beat is registered at the edge that takes the input beat.
// Throughput: one input beat per cycle, unless a held result beat or the memory clear stalls it.
// Reset: synchronous, active low; afterwards a clearing pass zeroes main memory while
// in_ready stays low (configuration writes are still taken).
// Control store rows are undefined until written.
// ----------------------------------------------------------------------------
// lc3b_microcoded_datapath_unit
// Microprogrammed LC-3b style core: each tick beat runs one microinstruction while the PC is nonzero.
// ----------------------------------------------------------------------------
module lc3b_microcoded_datapath_unit
  import lc3bmd_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // architectural state
  logic [5:0]  state_r, state_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [15:0] ir_r, ir_nxt;
  logic [15:0] mar_r, mar_nxt;
  logic [15:0] mdr_r, mdr_nxt;
  logic [2:0]  cc_r, cc_nxt;
  logic        ben_r, ben_nxt;
  logic        ready_r, ready_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] rf_r [NUM_REGS];

  out_t        out_r;
  logic        out_valid_r;

  logic        accept;
  logic        run;
  logic        mem_busy;
  uinst_t      uw;
  cs_wr_t      cs_wr;
  mem_wr_t     mem_wr;
  logic [15:0] mar_word;
  logic [15:0] rd_b;

  logic [15:0] sr1, sr2, adder, off, alu, shf, mdr_bus, bus;
  logic [5:0]  next_st;
  logic [2:0]  dr;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !mem_busy && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign run       = accept && (in_data.op == OP_TICK) && (pc_r != '0);

  // operand selection
  always_comb begin
    sr1 = uw.sr1mux ? rf_r[ir_r[8:6]] : rf_r[ir_r[11:9]];
    sr2 = ir_r[5] ? sext5(ir_r[4:0]) : rf_r[ir_r[2:0]];
  end

  // address adder
  always_comb begin
    case (uw.addr2mux)
      2'd1:    off = sext6(ir_r[5:0]);
      2'd2:    off = sext9(ir_r[8:0]);
      2'd3:    off = sext11(ir_r[10:0]);
      default: off = '0;
    endcase
    if (uw.lshf1) begin
      off = {off[14:0], 1'b0};
    end
    adder = (uw.addr1mux ? sr1 : pc_r) + off;
  end

  // ALU and shifter
  always_comb begin
    case (uw.aluk)
      2'd0:    alu = sr1 + sr2;
      2'd1:    alu = sr1 & sr2;
      2'd2:    alu = sr1 ^ sr2;
      default: alu = sr1;
    endcase
    case (ir_r[5:4])
      2'd0:    shf = sr1 << ir_r[3:0];
      2'd1:    shf = sr1 >> ir_r[3:0];
      default: shf = 16'($signed(sr1) >>> ir_r[3:0]);
    endcase
  end

  // MDR driver: word, or selected byte sign-extended
  always_comb begin
    if (uw.wsize) begin
      mdr_bus = mdr_r;
    end else if (mar_r[0]) begin
      mdr_bus = sext8(mdr_r[15:8]);
    end else begin
      mdr_bus = sext8(mdr_r[7:0]);
    end
  end

  // bus drivers in fixed priority
  always_comb begin
    bus = '0;
    if (uw.drv_marmux) begin
      bus = uw.marmux ? adder : {7'd0, ir_r[7:0], 1'b0};
    end else if (uw.drv_pc) begin
      bus = pc_r;
    end else if (uw.drv_alu) begin
      bus = alu;
    end else if (uw.drv_shf) begin
      bus = shf;
    end else if (uw.drv_mdr) begin
      bus = mdr_bus;
    end
  end

  // microsequencer
  always_comb begin
    if (uw.ird) begin
      next_st = {2'b00, ir_r[15:12]};
    end else begin
      case (uw.cond)
        COND_READY: next_st = uw.j | {4'd0, ready_r, 1'b0};
        COND_BEN:   next_st = uw.j | {3'd0, ben_r, 2'b00};
        COND_ADDR:  next_st = uw.j | {5'd0, ir_r[11]};
        default:    next_st = uw.j;
      endcase
    end
  end

  assign dr = uw.drmux ? 3'd7 : ir_r[11:9];

  // next architectural state and memory requests
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ir_nxt    = ir_r;
    mar_nxt   = mar_r;
    mdr_nxt   = mdr_r;
    cc_nxt    = cc_r;
    ben_nxt   = ben_r;
    ready_nxt = ready_r;
    cnt_nxt   = cnt_r;
    mem_wr    = '{en: 1'b0, addr: in_data.index, data: in_data.data[15:0]};
    cs_wr     = '{en: 1'b0, addr: in_data.index[CS_AW-1:0], data: uinst_t'(in_data.data)};

    if (accept && (in_data.op == OP_WR_CS)) begin
      cs_wr.en = in_data.index < 15'(CS_ROWS);
    end
    if (accept && (in_data.op == OP_WR_MEM)) begin
      mem_wr.en = 1'b1;
    end

    if (run) begin
      state_nxt = next_st;
      ready_nxt = 1'b0;
      if (uw.cond == COND_READY) begin
        if (cnt_r == 3'(MEM_LATENCY - 1)) begin
          ready_nxt = 1'b1;
          if (uw.r_w) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = mar_r[15:1];
            if (uw.wsize) begin
              mem_wr.data = mdr_r;
            end else if (mar_r[0]) begin
              mem_wr.data = {mdr_r[15:8], mar_word[7:0]};
            end else begin
              mem_wr.data = {mar_word[15:8], mdr_r[7:0]};
            end
          end
        end
        cnt_nxt = (cnt_r == 3'(MEM_LATENCY)) ? 3'd1 : cnt_r + 3'd1;
      end else begin
        cnt_nxt = 3'd1;
      end

      if (uw.ld_mar) begin
        mar_nxt = bus;
      end
      if (uw.ld_mdr) begin
        if (uw.mio_en) begin
          // a write landing in this cycle is what the load sees
          if (mem_wr.en && ({1'b0, mar_r[15:1]} < 16'(MEM_WORDS))) begin
            mdr_nxt = mem_wr.data;
          end else begin
            mdr_nxt = mar_word;
          end
        end else if (uw.wsize) begin
          mdr_nxt = bus;
        end else begin
          mdr_nxt = {bus[7:0], bus[7:0]};
        end
      end
      if (uw.ld_ir) begin
        ir_nxt = bus;
      end
      if (uw.ld_ben) begin
        ben_nxt = (cc_r[2] & ir_r[11]) | (cc_r[1] & ir_r[10]) | (cc_r[0] & ir_r[9]);
      end
      if (uw.ld_cc) begin
        cc_nxt = bus[15] ? CC_N : ((bus == '0) ? CC_Z : CC_P);
      end
      if (uw.ld_pc) begin
        case (uw.pcmux)
          2'd0:    pc_nxt = pc_r + 16'd2;
          2'd1:    pc_nxt = bus;
          default: pc_nxt = adder;
        endcase
      end
    end

    // start address load
    if (cfg_valid && cfg_ready) begin
      pc_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= START_STATE;
      pc_r    <= '0;
      ir_r    <= '0;
      mar_r   <= '0;
      mdr_r   <= '0;
      cc_r    <= CC_Z;
      ben_r   <= 1'b0;
      ready_r <= 1'b0;
      cnt_r   <= 3'd1;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ir_r    <= ir_nxt;
      mar_r   <= mar_nxt;
      mdr_r   <= mdr_nxt;
      cc_r    <= cc_nxt;
      ben_r   <= ben_nxt;
      ready_r <= ready_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else if (run && uw.ld_reg) begin
      rf_r[dr] <= bus;
    end
  end

  // result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.micro_state_out <= state_nxt;
      out_r.bus_value       <= run ? bus : '0;
      out_r.pc_value        <= pc_nxt;
      out_r.ir_value        <= ir_nxt;
      out_r.cc_nzp          <= cc_nxt;
      out_r.halted          <= (in_data.op == OP_TICK) && (pc_r == '0);
      out_r.read_data       <= '0;
    end
  end

  always_comb begin
    out_data           = out_r;
    out_data.read_data = rd_b;
  end

  assign out_valid = out_valid_r;

  lc3bmd_cstore u_cstore (
    .clk   (clk),
    .wr    (cs_wr),
    .raddr (state_nxt),
    .rdata (uw)
  );

  lc3bmd_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (mem_wr),
    .raddr_a  (mar_nxt[15:1]),
    .rdata_a  (mar_word),
    .rd_b_en  (accept),
    .rd_b_sel (in_data.op == OP_RD_MEM),
    .raddr_b  (in_data.index),
    .rdata_b  (rd_b),
    .busy     (mem_busy)
  );

endmodule

// File: rtl/lc3bmd_checker.sv
// ----------------------------------------------------------------------------
// lc3bmd_checker
// Port-level checks of the LC-3b microcoded datapath unit.
// ----------------------------------------------------------------------------
`include "lc3b_microcoded_datapath_unit_macros.svh"

module lc3bmd_checker
  import lc3bmd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `LC3BMD_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(out_data)), "result beat changed while stalled")
  `LC3BMD_ASSERT_NEXT(a_clear_blocks, !rst_n, !in_ready, "input taken during memory clear")
  `LC3BMD_ASSERT_IMP(a_halt_quiet, out_valid && out_data.halted, out_data.bus_value == '0 && out_data.read_data == '0, "halted beat drives bus or read data")
  `LC3BMD_ASSERT_IMP(a_cc_onehot, out_valid, $onehot(out_data.cc_nzp), "condition codes not one-hot")
  `LC3BMD_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && (in_data.op != OP_TICK), out_valid && !out_data.halted && (out_data.bus_value == '0), "non-tick beat shows halt or bus value")

endmodule

bind lc3b_microcoded_datapath_unit lc3bmd_checker u_lc3bmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/lc3b_microcoded_datapath_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LC-3b microcoded datapath unit testbench
// Drives control-store, memory and tick beats through the input channel,
// predicts every result beat with a cycle-level core model kept here, and
// compares each result field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module lc3b_microcoded_datapath_unit_test;
  import lc3bmd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  lc3b_microcoded_datapath_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Core shadow state: mirrors what the block holds after every accepted beat
  // --------------------------------------------------------------------------
  logic [34:0] ucode [CS_ROWS];
  logic [15:0] word_mem [MEM_WORDS_DEF];
  logic [15:0] gpr [NUM_REGS];
  logic [5:0]  upc;
  logic [15:0] pc;
  logic [15:0] ir;
  logic [15:0] mar;
  logic [15:0] mdr;
  logic [2:0]  nzp;
  logic        ben;
  logic        mready;
  logic [2:0]  mcount;

  out_t result_q [$];
  int   errors;
  int   results_seen;
  int   ticks_run;
  int   halts_seen;
  int   mem_writes_by_core;
  int   cycles;

  // receiver hold-off request, consumed by the out_ready process
  bit   hold_req;
  int   hold_left;
  int   stall_left;

  function automatic logic [15:0] sign_ext(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v;
    for (int b = bits; b < 16; b++) r[b] = v[bits-1];
    return r;
  endfunction

  function automatic logic [15:0] sr1_reg(input uinst_t u);
    return u.sr1mux ? gpr[ir[8:6]] : gpr[ir[11:9]];
  endfunction

  function automatic logic [15:0] addr_sum(input uinst_t u);
    logic [15:0] off;
    logic [15:0] base;
    case (u.addr2mux)
      2'd1:    off = sign_ext(ir, 6);
      2'd2:    off = sign_ext(ir, 9);
      2'd3:    off = sign_ext(ir, 11);
      default: off = 16'h0000;
    endcase
    if (u.lshf1) off = off << 1;
    base = u.addr1mux ? sr1_reg(u) : pc;
    return base + off;
  endfunction

  function automatic logic [15:0] alu_result(input uinst_t u);
    logic [15:0] a;
    logic [15:0] b;
    a = sr1_reg(u);
    b = ir[5] ? sign_ext(ir, 5) : gpr[ir[2:0]];
    case (u.aluk)
      2'd0:    return a + b;
      2'd1:    return a & b;
      2'd2:    return a ^ b;
      default: return a;
    endcase
  endfunction

  function automatic logic [15:0] shift_result(input uinst_t u);
    logic [15:0] v;
    v = sr1_reg(u);
    case (ir[5:4])
      2'd0:    return v << ir[3:0];
      2'd1:    return v >> ir[3:0];
      default: return $unsigned($signed(v) >>> ir[3:0]);
    endcase
  endfunction

  // One machine cycle of the core; returns the bus value
  function automatic logic [15:0] machine_cycle();
    uinst_t      u;
    logic [5:0]  nxt;
    logic        nrdy;
    logic [15:0] bus;
    logic [14:0] waddr;
    logic [15:0] n_mar, n_mdr, n_ir, n_pc;
    logic        n_ben;
    logic [2:0]  n_cc;
    u     = uinst_t'(ucode[upc]);
    waddr = mar[15:1];
    bus   = 16'h0000;
    if (u.ird)                    nxt = {2'b00, ir[15:12]};
    else if (u.cond == COND_READY) nxt = u.j | {4'b0, mready, 1'b0};
    else if (u.cond == COND_BEN)   nxt = u.j | {3'b0, ben, 2'b0};
    else if (u.cond == COND_ADDR)  nxt = u.j | {5'b0, ir[11]};
    else                           nxt = u.j;

    // memory timing: the write lands when the access counter reaches its ready value, and ready is raised with it
    nrdy = 1'b0;
    if (u.cond == COND_READY) begin
      if (mcount == 3'(MEM_LATENCY - 1)) begin
        if (u.r_w) begin
          mem_writes_by_core++;
          if (u.wsize) word_mem[waddr] = mdr;
          else if (mar[0]) word_mem[waddr][15:8] = mdr[15:8];
          else word_mem[waddr][7:0] = mdr[7:0];
        end
        nrdy = 1'b1;
      end
      mcount = (mcount == 3'(MEM_LATENCY)) ? 3'd1 : mcount + 3'd1;
    end else begin
      mcount = 3'd1;
    end

    if (u.drv_marmux) bus = u.marmux ? addr_sum(u) : {7'b0, ir[7:0], 1'b0};
    else if (u.drv_pc) bus = pc;
    else if (u.drv_alu) bus = alu_result(u);
    else if (u.drv_shf) bus = shift_result(u);
    else if (u.drv_mdr) begin
      if (u.wsize) bus = mdr;
      else if (mar[0]) bus = sign_ext({8'h00, mdr[15:8]}, 8);
      else bus = sign_ext({8'h00, mdr[7:0]}, 8);
    end

    n_mar = u.ld_mar ? bus : mar;
    n_mdr = mdr;
    if (u.ld_mdr) begin
      if (u.mio_en) n_mdr = word_mem[waddr];
      else if (u.wsize) n_mdr = bus;
      else n_mdr = {bus[7:0], bus[7:0]};
    end
    n_ir  = u.ld_ir ? bus : ir;
    n_ben = u.ld_ben ? ((nzp[2] & ir[11]) | (nzp[1] & ir[10]) | (nzp[0] & ir[9])) : ben;
    n_cc  = nzp;
    if (u.ld_cc) n_cc = bus[15] ? CC_N : ((bus == 16'h0000) ? CC_Z : CC_P);
    n_pc  = pc;
    if (u.ld_pc) begin
      case (u.pcmux)
        2'd0:    n_pc = pc + 16'd2;
        2'd1:    n_pc = bus;
        default: n_pc = addr_sum(u);
      endcase
    end
    if (u.ld_reg) gpr[u.drmux ? 3'd7 : ir[11:9]] = bus;
    mar    = n_mar;
    mdr    = n_mdr;
    ir     = n_ir;
    ben    = n_ben;
    nzp    = n_cc;
    pc     = n_pc;
    mready = nrdy;
    upc    = nxt;
    return bus;
  endfunction

  // Apply one accepted input beat to the shadow core and queue its result
  function automatic void predict_beat(input in_t b);
    out_t r;
    r = '0;
    case (b.op)
      OP_TICK: begin
        if (pc == 16'h0000) begin
          r.halted = 1'b1;
          halts_seen++;
        end else begin
          r.bus_value = machine_cycle();
          ticks_run++;
        end
      end
      OP_WR_CS:  if (b.index < CS_ROWS) ucode[b.index[5:0]] = b.data;
      OP_WR_MEM: word_mem[b.index] = b.data[15:0];
      default:   r.read_data = word_mem[b.index];
    endcase
    r.micro_state_out = upc;
    r.pc_value        = pc;
    r.ir_value        = ir;
    r.cc_nzp          = nzp;
    result_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one beat; leave valid up so a back-to-back beat needs no second edit
  task automatic send_beat(input logic [1:0] op, input logic [14:0] idx,
                           input logic [34:0] data, input bit gaps);
    in_t b;
    int  gap;
    b.op    = op;
    b.index = idx;
    b.data  = data;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    predict_beat(b);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued result has come back, then let the pipe drain
  task automatic wait_idle();
    drop_valid();
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pc      = v;
    @(posedge clk);
  endtask

  // Random microword: one bus driver most of the time, everything else random
  function automatic logic [34:0] random_uword();
    uinst_t u;
    u = uinst_t'({$urandom(), 3'($urandom())});
    {u.drv_pc, u.drv_mdr, u.drv_alu, u.drv_marmux, u.drv_shf} = 5'b0;
    case ($urandom_range(0, 6))
      0: u.drv_pc = 1'b1;
      1: u.drv_mdr = 1'b1;
      2: u.drv_alu = 1'b1;
      3: u.drv_marmux = 1'b1;
      4: u.drv_shf = 1'b1;
      5: {u.drv_pc, u.drv_mdr, u.drv_alu, u.drv_marmux, u.drv_shf} = 5'($urandom());
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) u.ird = 1'b0;
    return 35'(u);
  endfunction

  // Overwrite the row of the current state, then run it once
  task automatic run_word(input uinst_t u);
    send_beat(OP_WR_CS, 15'(upc), 35'(u), 1'b1);
    send_beat(OP_TICK, 15'd0, 35'd0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill every control-store row first so no tick ever fetches an unwritten row
  task automatic test_load_control_store();
    for (int r = 0; r < CS_ROWS; r++) begin
      if (r == 0) send_beat(OP_WR_CS, 15'(r), '1, 1'b1);
      else if (r == CS_ROWS - 1) send_beat(OP_WR_CS, 15'(r), '0, 1'b1);
      else send_beat(OP_WR_CS, 15'(r), random_uword(), 1'b1);
    end
    // rows past the end of the store are dropped
    send_beat(OP_WR_CS, 15'h7FFF, '1, 1'b1);
    send_beat(OP_WR_CS, 15'(CS_ROWS), '1, 1'b1);
  endtask

  task automatic test_memory_ports();
    send_beat(OP_WR_MEM, 15'd0, 35'h7_FFFF_FFFF, 1'b1);
    send_beat(OP_WR_MEM, 15'h7FFF, 35'h0_0000_A5A5, 1'b1);
    send_beat(OP_WR_MEM, 15'h2AAA, 35'h5_5555_5A5A, 1'b1);
    send_beat(OP_RD_MEM, 15'd0, '1, 1'b1);
    send_beat(OP_RD_MEM, 15'h7FFF, 35'd0, 1'b1);
    send_beat(OP_RD_MEM, 15'h2AAA, 35'd0, 1'b1);
    send_beat(OP_RD_MEM, 15'h1234, 35'd0, 1'b1);
  endtask

  // A tick with the PC at zero must report halted and change nothing
  task automatic test_halt();
    write_start_pc(16'h0000);
    send_beat(OP_TICK, 15'd0, 35'd0, 1'b1);
    send_beat(OP_TICK, 15'h7FFF, '1, 1'b1);
    write_start_pc(16'hFFFF);
  endtask

  // Every bus driver, ALU op, PC source and sequencing mode
  task automatic test_datapath_ops();
    uinst_t u;
    write_start_pc(16'h3000);
    // load IR from the bus under each driver in turn to get a rich instruction word
    for (int k = 0; k < 12; k++) begin
      u = '0;
      u.j = upc;
      u.ld_ir = 1'b1;
      u.ld_reg = 1'b1;
      u.ld_cc = 1'b1;
      u.ld_mar = 1'(k % 2);
      u.ld_mdr = 1'b1;
      u.wsize = (k % 3 != 0);
      u.aluk = 2'(k);
      u.pcmux = 2'(k >> 1);
      u.ld_pc = 1'b1;
      u.addr2mux = 2'(k);
      u.addr1mux = k[2];
      u.sr1mux = k[0];
      u.lshf1 = k[1];
      u.drmux = k[3];
      case (k % 5)
        0: u.drv_marmux = 1'b1;
        1: u.drv_pc = 1'b1;
        2: u.drv_alu = 1'b1;
        3: u.drv_shf = 1'b1;
        default: u.drv_mdr = 1'b1;
      endcase
      u.marmux = k[0];
      u.cond = 2'(k);
      u.ld_ben = 1'b1;
      if (k == 11) u.ird = 1'b1;
      run_word(u);
      // seed IR with different shift/imm patterns
      if (k == 0) send_beat(OP_WR_MEM, 15'(mar[15:1]), 35'h0000_8F3A, 1'b1);
    end
  endtask

  // Hold a state on the memory-ready loop for a full access, write then read
  task automatic test_memory_cycle();
    uinst_t u;
    for (int k = 0; k < 3; k++) begin
      u = '0;
      u.cond = COND_READY;
      u.j = 6'b110001;   // bit 1 clear so ready moves the state on
      u.r_w = (k != 2);
      u.wsize = (k == 0);
      u.mio_en = 1'b1;
      u.ld_mdr = 1'b1;
      u.drv_mdr = 1'b1;
      send_beat(OP_WR_CS, 15'h31, 35'(u), 1'b1);
      u.j = 6'b110011;
      send_beat(OP_WR_CS, 15'h33, 35'(u), 1'b1);
      u = '0;
      u.j = 6'h31;
      send_beat(OP_WR_CS, 15'(upc), 35'(u), 1'b1);
      for (int t = 0; t < 7; t++) send_beat(OP_TICK, 15'd0, 35'd0, 1'b1);
    end
  endtask

  // Mostly ticks with random microcode and memory, occasional rewrites
  task automatic test_random_program(input int count);
    int p;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      if (p < 60) send_beat(OP_TICK, 15'($urandom()), 35'({$urandom(), 3'($urandom())}), 1'b1);
      else if (p < 72) send_beat(OP_WR_CS, 15'($urandom_range(0, 69)), random_uword(), 1'b1);
      else if (p < 74) send_beat(OP_WR_CS, 15'($urandom()), 35'({$urandom(), 3'($urandom())}),
                                 1'b1);
      else if (p < 86) begin
        if ($urandom_range(0, 3) == 0)
          send_beat(OP_WR_MEM, 15'($urandom()), 35'({$urandom(), 3'($urandom())}), 1'b1);
        else
          send_beat(OP_WR_MEM, 15'(pc[15:1] + $urandom_range(0, 15)),
                    35'({$urandom(), 3'($urandom())}), 1'b1);
      end else if (p < 93) send_beat(OP_RD_MEM, 15'($urandom()), 35'd0, 1'b1);
      else send_beat(OP_RD_MEM, mar[15:1], 35'd0, 1'b1);
    end
  endtask

  // Receiver stops for a long stretch while beats keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_beat(OP_TICK, 15'd0, 35'd0, 1'b0);
    drop_valid();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls plus an optional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result beat with the oldest outstanding prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        errors++;
      end else begin
        want = result_q.pop_front();
        check_field("micro_state_out", 16'(want.micro_state_out), 16'(out_data.micro_state_out));
        check_field("bus_value", want.bus_value, out_data.bus_value);
        check_field("pc_value", want.pc_value, out_data.pc_value);
        check_field("ir_value", want.ir_value, out_data.ir_value);
        check_field("cc_nzp", 16'(want.cc_nzp), 16'(out_data.cc_nzp));
        check_field("halted", 16'(want.halted), 16'(out_data.halted));
        check_field("read_data", want.read_data, out_data.read_data);
      end
    end
  end

  // Watchdog: covers the post-reset memory clear and a slow, stalled run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lc3b_microcoded_datapath_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    errors    = 0;
    cycles    = 0;
    results_seen = 0;
    ticks_run = 0;
    halts_seen = 0;
    mem_writes_by_core = 0;
    // shadow reset state
    foreach (ucode[r]) ucode[r] = '0;
    foreach (word_mem[a]) word_mem[a] = '0;
    foreach (gpr[g]) gpr[g] = '0;
    upc = START_STATE;
    pc = 16'h0000;
    ir = '0;
    mar = '0;
    mdr = '0;
    nzp = CC_Z;
    ben = 1'b0;
    mready = 1'b0;
    mcount = 3'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_control_store();
    test_memory_ports();
    test_halt();
    test_datapath_ops();
    test_memory_cycle();
    write_start_pc(16'h0100);
    test_random_program(250);
    test_backpressure();
    write_start_pc(16'($urandom()) | 16'h0002);
    test_random_program(200);
    write_start_pc(16'h0000);
    test_random_program(20);
    write_start_pc(16'h0040);
    test_random_program(120);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("ran %0d machine cycles and %0d halted ticks; %0d result beats checked",
             ticks_run, halts_seen, results_seen);
    $display("core memory writes: %0d, long receiver hold-off exercised", mem_writes_by_core);
    if (errors == 0 && result_q.size() == 0) begin
      $display("lc3b_microcoded_datapath_unit_test OK");
    end else begin
      $display("lc3b_microcoded_datapath_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// File: lc3b_microcoded_datapath_unit.f
+incdir+rtl
rtl/lc3bmd_pkg.sv
rtl/lc3bmd_cstore.sv
rtl/lc3bmd_mem.sv
rtl/lc3b_microcoded_datapath_unit.sv
rtl/lc3bmd_checker.sv
tb/lc3b_microcoded_datapath_unit_test.sv
